/* rtl/cwst_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// cwst_pkg - shared types and constants for the circle span table
// Field layout of the stream items, operation codes and sequencer states.
// ============================================================================
package cwst_pkg;

    // Screen defaults
    localparam int SCREEN_W_DEF = 240;
    localparam int SCREEN_H_DEF = 160;

    // Item field widths
    localparam int CX_W     = 10;
    localparam int CY_W     = 10;
    localparam int RADIUS_W = 9;
    localparam int ROW_W    = 8;
    localparam int EDGE_W   = 8;
    localparam int SPAN_W   = 2 * EDGE_W;

    // Input tdata layout, lowest bit first
    localparam int CX_LSB     = 0;
    localparam int CY_LSB     = CX_LSB + CX_W;
    localparam int RADIUS_LSB = CY_LSB + CY_W;
    localparam int ROW_LSB    = RADIUS_LSB + RADIUS_W;
    localparam int S_FIELDS_W = ROW_LSB + ROW_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = SPAN_W;

    // Walk arithmetic widths
    localparam int COORD_W = 10;   // x / y walk coordinates, signed
    localparam int SUM_W   = 12;   // center +/- offset, signed
    localparam int DEC_W   = 13;   // midpoint decision variable, signed

    // Operation codes carried in s_axis_tuser
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [1:0] {
        T_IDLE,
        T_DRAW,
        T_READ
    } top_state_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_SIDE_A,   // row cy - x, half width y
        W_SIDE_B,   // row cy + x, half width y
        W_TOP_A,    // row cy - y, half width x
        W_TOP_B     // row cy + y, half width x
    } walk_state_t;

    typedef struct packed {
        logic wr_en;
        logic done;
    } walk_ctl_t;

endpackage

/* rtl/cwst_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// cwst_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module cwst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cwst_span_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// cwst_span_unit - shared span and row arithmetic
// Forms one clamped span (cx +/- half) and one target row (cy +/- off).
// ============================================================================
module cwst_span_unit #(
    parameter int SCREEN_W = cwst_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cwst_pkg::SCREEN_H_DEF
) (
    input  logic signed [cwst_pkg::COORD_W-1:0] cx,
    input  logic signed [cwst_pkg::COORD_W-1:0] cy,
    input  logic signed [cwst_pkg::COORD_W-1:0] half,
    input  logic signed [cwst_pkg::COORD_W-1:0] off,
    input  logic                                neg,
    output logic [cwst_pkg::SPAN_W-1:0]         span,
    output logic                                row_ok,
    output logic [$clog2(SCREEN_H)-1:0]         row
);

    localparam int SW = cwst_pkg::SUM_W;
    localparam int EXT = SW - cwst_pkg::COORD_W;
    localparam logic signed [SW-1:0] W_S = SW'(SCREEN_W);
    localparam logic signed [SW-1:0] H_S = SW'(SCREEN_H);

    logic signed [SW-1:0] cx_e, cy_e, half_e, off_e;
    logic signed [SW-1:0] right_v, left_v, row_v;

    function automatic logic [cwst_pkg::EDGE_W-1:0] clamp_edge(logic signed [SW-1:0] v);
        logic [cwst_pkg::EDGE_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > W_S)
            r = W_S[cwst_pkg::EDGE_W-1:0];
        else
            r = v[cwst_pkg::EDGE_W-1:0];
        return r;
    endfunction

    assign cx_e   = {{EXT{cx[cwst_pkg::COORD_W-1]}}, cx};
    assign cy_e   = {{EXT{cy[cwst_pkg::COORD_W-1]}}, cy};
    assign half_e = {{EXT{half[cwst_pkg::COORD_W-1]}}, half};
    assign off_e  = {{EXT{off[cwst_pkg::COORD_W-1]}}, off};

    assign right_v = cx_e + half_e;
    assign left_v  = cx_e - half_e;
    assign row_v   = neg ? (cy_e - off_e) : (cy_e + off_e);

    assign span   = {clamp_edge(left_v), clamp_edge(right_v)};
    assign row_ok = (row_v >= 0) && (row_v < H_S);
    assign row    = row_v[$clog2(SCREEN_H)-1:0];

endmodule

/* rtl/cwst_walker.sv */
`timescale 1ns / 1ps
// ============================================================================
// cwst_walker - midpoint circle sequencer
// Steps the octant walk and issues one table write per cycle while walking; rows off the screen are skipped.
// ============================================================================
module cwst_walker #(
    parameter int SCREEN_W = cwst_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cwst_pkg::SCREEN_H_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [cwst_pkg::CX_W-1:0]     cx,
    input  logic signed [cwst_pkg::CY_W-1:0]     cy,
    input  logic [cwst_pkg::RADIUS_W-1:0]        radius,
    output cwst_pkg::walk_ctl_t                  ctl,
    output logic [$clog2(SCREEN_H)-1:0]          wr_addr,
    output logic [cwst_pkg::SPAN_W-1:0]          wr_data
);

    localparam int CW = cwst_pkg::COORD_W;
    localparam int DW = cwst_pkg::DEC_W;

    cwst_pkg::walk_state_t state_reg, state_next;

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;

    logic signed [CW-1:0] half, off;
    logic                 neg;
    logic                 row_ok;
    logic                 step_x_only;   // update without a y step
    logic                 step_xy;       // update with a y step

    logic signed [CW-1:0] x_inc, y_dec, y_upd;
    logic signed [DW-1:0] two_x, two_y_dec, d_upd;

    cwst_span_unit #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_span (
        .cx     (cx_reg),
        .cy     (cy_reg),
        .half   (half),
        .off    (off),
        .neg    (neg),
        .span   (wr_data),
        .row_ok (row_ok),
        .row    (wr_addr)
    );

    // step update: x++, optionally y-- with the matching decision change
    assign x_inc     = x_reg + CW'(1);
    assign y_dec     = y_reg - CW'(1);
    assign two_x     = {{(DW-CW-1){x_reg[CW-1]}}, x_reg, 1'b0};
    assign two_y_dec = {{(DW-CW-1){y_dec[CW-1]}}, y_dec, 1'b0};
    assign y_upd     = step_xy ? y_dec : y_reg;
    assign d_upd     = d_reg + two_x + DW'(3) - (step_xy ? two_y_dec : DW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cwst_pkg::W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        d_reg  <= d_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        half        = y_reg;
        off         = x_reg;
        neg         = 1'b1;
        step_x_only = 1'b0;
        step_xy     = 1'b0;
        ctl.wr_en   = 1'b0;
        ctl.done    = 1'b0;

        case (state_reg)
            cwst_pkg::W_IDLE:
            begin
                if (start)
                begin
                    cx_next    = cx;
                    cy_next    = cy;
                    x_next     = '0;
                    y_next     = {1'b0, radius};
                    d_next     = DW'(1) - {{(DW-cwst_pkg::RADIUS_W){1'b0}}, radius};
                    state_next = cwst_pkg::W_SIDE_A;
                end
            end
            cwst_pkg::W_SIDE_A:
            begin
                ctl.wr_en  = row_ok;
                state_next = cwst_pkg::W_SIDE_B;
            end
            cwst_pkg::W_SIDE_B:
            begin
                neg       = 1'b0;
                ctl.wr_en = row_ok;
                if (d_reg >= 0)
                    state_next = cwst_pkg::W_TOP_A;
                else
                    step_x_only = 1'b1;
            end
            cwst_pkg::W_TOP_A:
            begin
                half       = x_reg;
                off        = y_reg;
                ctl.wr_en  = row_ok;
                state_next = cwst_pkg::W_TOP_B;
            end
            cwst_pkg::W_TOP_B:
            begin
                half      = x_reg;
                off       = y_reg;
                neg       = 1'b0;
                ctl.wr_en = row_ok;
                step_xy   = 1'b1;
            end
            default:
            begin
                state_next = cwst_pkg::W_IDLE;
            end
        endcase

        if (step_x_only || step_xy)
        begin
            x_next = x_inc;
            y_next = y_upd;
            d_next = d_upd;
            if (y_upd >= x_inc)
            begin
                state_next = cwst_pkg::W_SIDE_A;
            end
            else
            begin
                state_next = cwst_pkg::W_IDLE;
                ctl.done   = 1'b1;
            end
        end
    end

endmodule

/* rtl/circle_window_span_table.sv */
`timescale 1ns / 1ps
// Read: the row's RAM word and hit flag are registered on acceptance; T_READ loads them into the result register.
// A draw item steps through SIDE_A and SIDE_B on a walk step without a row step, and also through TOP_A and TOP_B
// on one with a row step; the walk has about radius*0.71 + 1 steps.
// Throughput: one item at a time; the next is taken once the result is taken.
// Reset: rst_n async active low; the span table reads zero right after reset.
// ============================================================================
// circle_window_span_table - filled circle scanline span table
// Midpoint circle walk that fills a per-row table of window edges, and a
// read port that returns one row's edges per item.
// ============================================================================
module circle_window_span_table #(
    parameter int SCREEN_W = cwst_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cwst_pkg::SCREEN_H_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // center_x[9:0], center_y[19:10], radius[28:20], row_index[36:29], zero pad
    input  logic [cwst_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func: 0 draw, 1 read
    input  logic                           s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // right_edge[7:0], left_edge[15:8]
    output logic [cwst_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // draw_done
    output logic                           m_axis_tuser
);

    // ------------------------------------------------------------------
    // The table holds rows 0..SCREEN_H-1 in a RAM. The extra row SCREEN_H
    // always equals row 0 after a draw, so a read of it is steered to
    // row 0. A per-row valid flag stands for the all-zero clear: it is
    // dropped for every row on reset and at the start of each draw, and
    // an invalid row reads as zero.
    // ------------------------------------------------------------------
    localparam int AW = $clog2(SCREEN_H);
    localparam int RW = cwst_pkg::ROW_W + 2;   // wide enough for SCREEN_H
    localparam logic [RW-1:0] H_ROW = RW'(SCREEN_H);

    cwst_pkg::top_state_t state_reg, state_next;

    logic                           out_valid_reg, out_valid_next;
    logic [cwst_pkg::SPAN_W-1:0]    out_data_reg, out_data_next;
    logic                           out_done_reg, out_done_next;
    logic [SCREEN_H-1:0]            vld_reg, vld_next;
    logic                           rd_hit_reg;

    logic                           accept;
    logic                           walk_start;
    cwst_pkg::walk_ctl_t            walk_ctl;
    logic [AW-1:0]                  wr_addr;
    logic [cwst_pkg::SPAN_W-1:0]    wr_data;
    logic [AW-1:0]                  rd_addr;
    logic [cwst_pkg::SPAN_W-1:0]    rd_data;
    logic [RW-1:0]                  row_ext;
    logic                           row_below;
    logic                           row_mirror;
    logic                           rd_hit;

    // Input field unpack
    logic signed [cwst_pkg::CX_W-1:0]  in_cx;
    logic signed [cwst_pkg::CY_W-1:0]  in_cy;
    logic [cwst_pkg::RADIUS_W-1:0]     in_radius;
    logic [cwst_pkg::ROW_W-1:0]        in_row;

    assign in_cx     = $signed(s_axis_tdata[cwst_pkg::CX_LSB +: cwst_pkg::CX_W]);
    assign in_cy     = $signed(s_axis_tdata[cwst_pkg::CY_LSB +: cwst_pkg::CY_W]);
    assign in_radius = s_axis_tdata[cwst_pkg::RADIUS_LSB +: cwst_pkg::RADIUS_W];
    assign in_row    = s_axis_tdata[cwst_pkg::ROW_LSB +: cwst_pkg::ROW_W];

    // Handshake: one item in flight; ready only with an empty output register
    assign s_axis_tready = (state_reg == cwst_pkg::T_IDLE) && !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_done_reg;

    // Read address: rows past the table read zero, the mirror row reads row 0
    assign row_ext    = {2'b00, in_row};
    assign row_below  = row_ext < H_ROW;
    assign row_mirror = row_ext == H_ROW;
    assign rd_addr    = row_below ? row_ext[AW-1:0] : '0;
    assign rd_hit     = (row_below || row_mirror) && vld_reg[rd_addr];

    // Midpoint walk sequencer with its span / row unit
    cwst_walker #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .cx      (in_cx),
        .cy      (in_cy),
        .radius  (in_radius),
        .ctl     (walk_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Span table storage
    cwst_ram #(
        .WIDTH (cwst_pkg::SPAN_W),
        .DEPTH (SCREEN_H)
    ) u_table (
        .clk     (clk),
        .wr_en   (walk_ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwst_pkg::T_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
        rd_hit_reg   <= rd_hit;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_done_next  = out_done_reg;
        vld_next       = vld_reg;
        walk_start     = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (walk_ctl.wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end

        case (state_reg)
            cwst_pkg::T_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == cwst_pkg::FUNC_DRAW)
                    begin
                        // whole table cleared at once
                        walk_start = 1'b1;
                        vld_next   = '0;
                        state_next = cwst_pkg::T_DRAW;
                    end
                    else
                    begin
                        state_next = cwst_pkg::T_READ;
                    end
                end
            end
            cwst_pkg::T_DRAW:
            begin
                if (walk_ctl.done)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_done_next  = 1'b1;
                    state_next     = cwst_pkg::T_IDLE;
                end
            end
            cwst_pkg::T_READ:
            begin
                // RAM data for the accepted row is out now
                out_valid_next = 1'b1;
                out_data_next  = rd_hit_reg ? rd_data : '0;
                out_done_next  = 1'b0;
                state_next     = cwst_pkg::T_IDLE;
            end
            default:
            begin
                state_next = cwst_pkg::T_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_write_only_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        walk_ctl.wr_en |-> (state_reg == cwst_pkg::T_DRAW))
        else $error("table write outside a draw");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_ctl.wr_en |-> ({1'b0, wr_addr} < (AW + 1)'(SCREEN_H)))
        else $error("table write beyond the screen rows");

    a_ack_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("draw acknowledge carries nonzero edges");

    a_done_gives_ack: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cwst_pkg::T_DRAW) && walk_ctl.done)
            |=> (m_axis_tvalid && m_axis_tuser))
        else $error("finished draw not acknowledged");

endmodule

/* test/circle_window_span_table_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// circle_window_span_table_tb - self-checking bench for the circle span table
// Drives draw and read items over the input stream and keeps its own copy of
// the 161-row span table, rebuilt by a midpoint circle walk on every draw.
// Each returned item is checked field by field against the oldest prediction.
// Both stream sides idle and stall at random.
// ============================================================================
module circle_window_span_table_tb;
    import cwst_pkg::*;

    localparam int SCR_W       = SCREEN_W_DEF;
    localparam int SCR_H       = SCREEN_H_DEF;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_OPS  = 1150;
    localparam int DRAIN_WAIT  = 10;

    // One input item as the bench sees it; hold makes the sender wait until
    // every outstanding result is back before offering it.
    typedef struct {
        logic                   func;
        logic signed [CX_W-1:0] cx;
        logic signed [CY_W-1:0] cy;
        logic [RADIUS_W-1:0]    radius;
        logic [ROW_W-1:0]       row;
        bit                     hold;
    } span_op_t;

    typedef struct {
        logic [EDGE_W-1:0] right_edge;
        logic [EDGE_W-1:0] left_edge;
        logic              draw_done;
    } span_result_t;

    // Receiver back-pressure styles
    typedef enum {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_CHOKE
    } rx_mode_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = FUNC_READ;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    span_op_t     pending_ops[$];
    span_result_t expected_spans[$];
    logic [SPAN_W-1:0] span_rows [0:SCR_H];

    int       items_taken  = 0;
    int       results_seen = 0;
    int       errors       = 0;
    int       cycle_count  = 0;
    int       burst_left   = 4;
    int       gap_left     = 0;
    int       mode_left    = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    circle_window_span_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin : clock_gen
        forever #1 clk = ~clk;
    end

    initial
    begin : reset_gen
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Span table predictor
    // ------------------------------------------------------------------
    function automatic int clamp_edge(int v);
        if (v < 0)
            return 0;
        if (v > SCR_W)
            return SCR_W;
        return v;
    endfunction

    // {left, right} edges of a span of half width half around column cx
    function automatic logic [SPAN_W-1:0] span_of(int cx, int half);
        logic [EDGE_W-1:0] right_e;
        logic [EDGE_W-1:0] left_e;
        right_e = EDGE_W'(clamp_edge(cx + half));
        left_e  = EDGE_W'(clamp_edge(cx - half));
        return {left_e, right_e};
    endfunction

    // walk rows off the screen are dropped
    task automatic put_row(int row, logic [SPAN_W-1:0] span);
        if (row >= 0 && row < SCR_H)
            span_rows[row] = span;
    endtask

    // Applies one accepted item to the table copy and queues its result.
    task automatic predict_span_result(span_op_t op);
        span_result_t      res;
        int                cx;
        int                cy;
        int                px;
        int                py;
        int                dec;
        logic [SPAN_W-1:0] span;
        res.right_edge = '0;
        res.left_edge  = '0;
        res.draw_done  = 1'b0;
        if (op.func == FUNC_DRAW) begin
            cx  = op.cx;
            cy  = op.cy;
            px  = 0;
            py  = op.radius;
            dec = 1 - py;
            for (int i = 0; i <= SCR_H; i++)
                span_rows[i] = '0;
            while (py >= px) begin
                // side octants: rows cy -/+ px, half width py
                span = span_of(cx, py);
                put_row(cy - px, span);
                put_row(cy + px, span);
                if (dec >= 0) begin
                    // row step: top and bottom octants, half width px
                    span = span_of(cx, px);
                    put_row(cy - py, span);
                    put_row(cy + py, span);
                    py--;
                    dec -= 2 * py;
                end
                dec += 2 * px + 3;
                px++;
            end
            span_rows[SCR_H] = span_rows[0];
            res.draw_done = 1'b1;
        end else if (op.row <= SCR_H) begin
            span = span_rows[op.row];
            res.right_edge = span[EDGE_W-1:0];
            res.left_edge  = span[SPAN_W-1:EDGE_W];
        end
        expected_spans.push_back(res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Unused fields of each item carry random noise.
    task automatic queue_draw(int cx, int cy, int r, bit hold = 1'b0);
        span_op_t op;
        op.func   = FUNC_DRAW;
        op.cx     = CX_W'(cx);
        op.cy     = CY_W'(cy);
        op.radius = RADIUS_W'(r);
        op.row    = ROW_W'($urandom_range(0, 255));
        op.hold   = hold;
        pending_ops.push_back(op);
    endtask

    task automatic queue_read(int row);
        span_op_t op;
        op.func   = FUNC_READ;
        op.cx     = CX_W'($urandom_range(0, 1023));
        op.cy     = CY_W'($urandom_range(0, 1023));
        op.radius = RADIUS_W'($urandom_range(0, 511));
        op.row    = ROW_W'(row);
        op.hold   = 1'b0;
        pending_ops.push_back(op);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of items separated by random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        span_op_t             op;
        logic [S_TDATA_W-1:0] word;
        bit                   busy;
        if (rst_n) begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_span_result(pending_ops.pop_front());
                items_taken++;
                busy = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: gap_left = 0;
                        5, 6, 7:       gap_left = $urandom_range(1, 4);
                        default:       gap_left = $urandom_range(5, 30);
                    endcase
                end
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0 &&
                             (!pending_ops[0].hold || items_taken == results_seen)) begin
                    op   = pending_ops[0];
                    word = '0;
                    word[CX_LSB     +: CX_W]     = op.cx;
                    word[CY_LSB     +: CY_W]     = op.cy;
                    word[RADIUS_LSB +: RADIUS_W] = op.radius;
                    word[ROW_LSB    +: ROW_W]    = op.row;
                    s_axis_tdata  <= word;
                    s_axis_tuser  <= op.func;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, drives its own stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : collect
        span_result_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_spans.size() == 0) begin
                    report_mismatch("unexpected item", m_axis_tdata, 0);
                end else begin
                    want = expected_spans.pop_front();
                    if (m_axis_tdata[EDGE_W-1:0] !== want.right_edge)
                        report_mismatch("right_edge", m_axis_tdata[EDGE_W-1:0],
                                        want.right_edge);
                    if (m_axis_tdata[SPAN_W-1:EDGE_W] !== want.left_edge)
                        report_mismatch("left_edge", m_axis_tdata[SPAN_W-1:EDGE_W],
                                        want.left_edge);
                    if (m_axis_tuser !== want.draw_done)
                        report_mismatch("draw_done", m_axis_tuser, want.draw_done);
                end
                results_seen <= results_seen + 1;
            end

            // stall style switches when its random run length runs out
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[circle_window_span_table] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int total;
        int reads;
        int cx;
        int cy;
        int r;
        for (int i = 0; i <= SCR_H; i++)
            span_rows[i] = '0;

        // table is empty after reset; mirror row, beyond-table rows
        queue_read(0);
        queue_read(SCR_H);
        queue_read(SCR_H + 1);
        queue_read(255);
        // radius zero: only the center row
        queue_draw(120, 80, 0);
        queue_read(80);
        queue_read(79);
        // circle running off the top and bottom of the screen
        queue_draw(120, 80, 100);
        queue_read(0);
        queue_read(80);
        queue_read(SCR_H - 1);
        queue_read(SCR_H);
        // circle on row 0, copied into the mirror row
        queue_draw(5, 0, 10);
        queue_read(SCR_H);
        queue_read(0);
        // field extremes: whole circle off screen, then one touching row 0
        queue_draw(511, -512, 511);
        queue_read(0);
        queue_draw(-512, 511, 511);
        queue_read(0);
        queue_read(SCR_H - 1);
        // largest radius over the screen, offered only once all is drained
        queue_draw(120, 80, 511, 1'b1);
        queue_read(40);
        // bottom-left corner
        queue_draw(-1, SCR_H - 1, 1);
        queue_read(SCR_H - 1);
        queue_read(SCR_H - 2);

        // random: draws, most followed by a run of reads
        total = 0;
        while (total < RANDOM_OPS) begin
            case ($urandom_range(0, 9))
                0: begin
                    cx = int'($urandom_range(0, 1023)) - 512;
                    cy = int'($urandom_range(0, 1023)) - 512;
                    r  = $urandom_range(0, 511);
                end
                1: begin
                    cx = int'($urandom_range(0, 300)) - 30;
                    cy = int'($urandom_range(0, 220)) - 30;
                    r  = $urandom_range(0, 511);
                end
                default: begin
                    cx = int'($urandom_range(0, 300)) - 30;
                    cy = int'($urandom_range(0, 220)) - 30;
                    r  = $urandom_range(0, 90);
                end
            endcase
            queue_draw(cx, cy, r, $urandom_range(0, 24) == 0);
            total++;
            reads = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(3, 16);
            repeat (reads) begin
                queue_read(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, SCR_H));
                total++;
            end
        end

        wait (rst_n === 1'b1);
        while (pending_ops.size() != 0 || items_taken != results_seen)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_spans.size() != 0)
            report_mismatch("results never returned", expected_spans.size(), 0);
        if (errors == 0)
            $display("[circle_window_span_table] OK");
        else
            $display("[circle_window_span_table] ERROR");
        $finish;
    end

endmodule
